>>> hw/rtl/mandelbrot_escape_pixel_assert.svh
// ----------------------------------------------------------------------------
// mandelbrot_escape_pixel assertion macros
// Shared concurrent checks on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef MANDELBROT_ESCAPE_PIXEL_ASSERT_SVH
`define MANDELBROT_ESCAPE_PIXEL_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MEP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mandelbrot_escape_pixel: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define MEP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mandelbrot_escape_pixel: next-cycle check failed");

`endif

>>> hw/rtl/mep_pkg.sv
// ----------------------------------------------------------------------------
// mep_pkg
// Types, widths, register codes and helpers for the escape-time pixel block.
// ----------------------------------------------------------------------------
package mep_pkg;

  localparam int COORD_WIDTH    = 32;
  localparam int ITER_WIDTH     = 16;
  localparam int FRAC_BITS      = COORD_WIDTH - 4;
  localparam int STEP_WIDTH     = COORD_WIDTH - 1;
  localparam int DIM_WIDTH      = 13;
  localparam int IDX_WIDTH      = 12;
  localparam int SHADE_WIDTH    = 8;
  localparam int PROD_WIDTH     = 2 * COORD_WIDTH - FRAC_BITS;
  localparam int OFS_WIDTH      = STEP_WIDTH + IDX_WIDTH;
  localparam int EXT_WIDTH      = COORD_WIDTH + 14;
  localparam int NUM_WIDTH      = ITER_WIDTH + SHADE_WIDTH;
  localparam int DIV_BIT_WIDTH  = $clog2(SHADE_WIDTH);
  localparam int CFG_IDX_WIDTH  = 3;
  localparam int CFG_DATA_WIDTH = COORD_WIDTH;

  localparam logic signed [COORD_WIDTH-1:0] X_START_RESET =
    -(COORD_WIDTH'(1) <<< (FRAC_BITS + 1));
  localparam logic signed [COORD_WIDTH-1:0] Y_TOP_RESET = COORD_WIDTH'(1) <<< FRAC_BITS;
  localparam logic [STEP_WIDTH-1:0] STEP_RESET = STEP_WIDTH'(1) << (FRAC_BITS - 7);
  localparam logic [ITER_WIDTH-1:0] MAX_ITERS_RESET = ITER_WIDTH'(255);
  localparam logic [DIM_WIDTH-1:0] IMG_DIM_RESET = DIM_WIDTH'(256);

  localparam logic signed [PROD_WIDTH:0] ESC_LIMIT = (PROD_WIDTH + 1)'(4) <<< FRAC_BITS;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_X_START    = 3'd0,
    REG_Y_TOP      = 3'd1,
    REG_STEP       = 3'd2,
    REG_MAX_ITERS  = 3'd3,
    REG_IMG_WIDTH  = 3'd4,
    REG_IMG_HEIGHT = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [IDX_WIDTH-1:0] col;
    logic [IDX_WIDTH-1:0] row;
  } mep_in_t;

  typedef struct packed {
    logic [SHADE_WIDTH-1:0] shade;
    logic [ITER_WIDTH-1:0]  iter_count;
    logic                   escaped;
  } mep_out_t;

  typedef struct packed {
    logic                     capture;
    logic                     set_c;
    logic                     square;
    logic                     update;
    logic                     finish;
    logic                     div_step;
    logic [DIV_BIT_WIDTH-1:0] div_bit;
    logic                     out_load;
  } mep_cmd_t;

  typedef struct packed {
    logic in_image;
    logic escape;
    logic at_limit;
  } mep_status_t;

  function automatic logic signed [COORD_WIDTH-1:0] sat_coord(
    input logic signed [EXT_WIDTH-1:0] v
  );
    if ((&v[EXT_WIDTH-1:COORD_WIDTH-1]) || !(|v[EXT_WIDTH-1:COORD_WIDTH-1])) begin
      return v[COORD_WIDTH-1:0];
    end else if (v[EXT_WIDTH-1]) begin
      return {1'b1, {(COORD_WIDTH-1){1'b0}}};
    end else begin
      return {1'b0, {(COORD_WIDTH-1){1'b1}}};
    end
  endfunction

endpackage

>>> hw/rtl/mep_dp.sv
// ----------------------------------------------------------------------------
// mep_dp
// Datapath: configuration registers, c set-up, complex square and update,
// escape test, shade divider and result register.
// ----------------------------------------------------------------------------
`include "mandelbrot_escape_pixel_assert.svh"

module mep_dp import mep_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_WIDTH-1:0]  cfg_addr,
  input  logic [CFG_DATA_WIDTH-1:0] cfg_wdata,
  input  mep_in_t                   in_data,
  input  mep_cmd_t                  cmd,
  output mep_status_t               st,
  output mep_out_t                  out_data
);

  logic signed [COORD_WIDTH-1:0] x_start;
  logic signed [COORD_WIDTH-1:0] y_top;
  logic [STEP_WIDTH-1:0]         step;
  logic [ITER_WIDTH-1:0]         max_iters;
  logic [DIM_WIDTH-1:0]          img_width;
  logic [DIM_WIDTH-1:0]          img_height;

  logic [OFS_WIDTH-1:0]          ofs_x;
  logic [OFS_WIDTH-1:0]          ofs_y;
  logic signed [COORD_WIDTH-1:0] cr;
  logic signed [COORD_WIDTH-1:0] ci;
  logic signed [COORD_WIDTH-1:0] zr;
  logic signed [COORD_WIDTH-1:0] zi;
  logic signed [PROD_WIDTH-1:0]  prr;
  logic signed [PROD_WIDTH-1:0]  pii;
  logic signed [PROD_WIDTH-1:0]  pri;
  logic [ITER_WIDTH-1:0]         k;
  logic [ITER_WIDTH-1:0]         cnt;
  logic                          esc_flag;
  logic [NUM_WIDTH-1:0]          num;
  logic [SHADE_WIDTH-1:0]        quo;

  logic signed [EXT_WIDTH-1:0]     x_ext;
  logic signed [EXT_WIDTH-1:0]     y_ext;
  logic signed [EXT_WIDTH-1:0]     ox_ext;
  logic signed [EXT_WIDTH-1:0]     oy_ext;
  logic signed [EXT_WIDTH-1:0]     re_ext;
  logic signed [EXT_WIDTH-1:0]     im_ext;
  logic signed [2*COORD_WIDTH-1:0] m_rr;
  logic signed [2*COORD_WIDTH-1:0] m_ii;
  logic signed [2*COORD_WIDTH-1:0] m_ri;
  logic signed [PROD_WIDTH:0]      sumsq;
  logic [ITER_WIDTH-1:0]           cnt_next;
  logic [NUM_WIDTH-1:0]            dsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_start    <= X_START_RESET;
      y_top      <= Y_TOP_RESET;
      step       <= STEP_RESET;
      max_iters  <= MAX_ITERS_RESET;
      img_width  <= IMG_DIM_RESET;
      img_height <= IMG_DIM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_X_START:    x_start    <= cfg_wdata[COORD_WIDTH-1:0];
        REG_Y_TOP:      y_top      <= cfg_wdata[COORD_WIDTH-1:0];
        REG_STEP:       step       <= cfg_wdata[STEP_WIDTH-1:0];
        REG_MAX_ITERS:  max_iters  <= cfg_wdata[ITER_WIDTH-1:0];
        REG_IMG_WIDTH:  img_width  <= cfg_wdata[DIM_WIDTH-1:0];
        REG_IMG_HEIGHT: img_height <= cfg_wdata[DIM_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  assign x_ext  = EXT_WIDTH'(x_start);
  assign y_ext  = EXT_WIDTH'(y_top);
  assign ox_ext = EXT_WIDTH'(ofs_x);
  assign oy_ext = EXT_WIDTH'(ofs_y);

  assign m_rr = zr * zr;
  assign m_ii = zi * zi;
  assign m_ri = zr * zi;

  assign re_ext = EXT_WIDTH'(prr) - EXT_WIDTH'(pii) + EXT_WIDTH'(cr);
  assign im_ext = (EXT_WIDTH'(pri) <<< 1) + EXT_WIDTH'(ci);

  assign sumsq = (PROD_WIDTH + 1)'(prr) + (PROD_WIDTH + 1)'(pii);

  assign st.in_image = ({1'b0, in_data.col} < img_width) && ({1'b0, in_data.row} < img_height);
  assign st.escape   = (k != '0) && (sumsq >= ESC_LIMIT);
  assign st.at_limit = (k == max_iters);

  assign cnt_next = st.escape ? k - 1'b1 : max_iters;
  assign dsh      = NUM_WIDTH'(max_iters) << cmd.div_bit;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ofs_x <= {{IDX_WIDTH{1'b0}}, step} * {{STEP_WIDTH{1'b0}}, in_data.col};
      ofs_y <= {{IDX_WIDTH{1'b0}}, step} * {{STEP_WIDTH{1'b0}}, in_data.row};
    end
    if (cmd.set_c) begin
      cr <= sat_coord(x_ext + ox_ext);
      ci <= sat_coord(y_ext - oy_ext);
      zr <= sat_coord(x_ext + ox_ext);
      zi <= sat_coord(y_ext - oy_ext);
      k  <= '0;
    end
    if (cmd.square) begin
      prr <= m_rr[2*COORD_WIDTH-1:FRAC_BITS];
      pii <= m_ii[2*COORD_WIDTH-1:FRAC_BITS];
      pri <= m_ri[2*COORD_WIDTH-1:FRAC_BITS];
    end
    if (cmd.update) begin
      zr <= sat_coord(re_ext);
      zi <= sat_coord(im_ext);
      k  <= k + 1'b1;
    end
    if (cmd.finish) begin
      cnt      <= cnt_next;
      esc_flag <= st.escape;
      num      <= {cnt_next, {SHADE_WIDTH{1'b0}}} - NUM_WIDTH'(cnt_next);
      quo      <= '0;
    end
    if (cmd.div_step) begin
      if (num >= dsh) begin
        num               <= num - dsh;
        quo[cmd.div_bit]  <= 1'b1;
      end
    end
    if (cmd.out_load) begin
      out_data.shade      <= quo;
      out_data.iter_count <= cnt;
      out_data.escaped    <= esc_flag;
    end
  end

  `MEP_ASSERT_NOW(a_iter_in_range, cmd.square, k <= max_iters)
  `MEP_ASSERT_NOW(a_count_in_range, cmd.div_step, cnt <= max_iters)
  `MEP_ASSERT_NEXT(a_update_counts, cmd.update, k != '0)

endmodule

>>> hw/rtl/mep_ctrl.sv
// ----------------------------------------------------------------------------
// mep_ctrl
// Controller: input and output handshakes, iteration sequencing and the
// bit-by-bit shade division.
// ----------------------------------------------------------------------------
`include "mandelbrot_escape_pixel_assert.svh"

module mep_ctrl import mep_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  mep_status_t st,
  output mep_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CSET,
    S_SQ,
    S_UPD,
    S_DIV,
    S_OUT
  } state_t;

  state_t                   state;
  logic [DIV_BIT_WIDTH-1:0] div_bit;
  logic                     done;

  assign in_ready = (state == S_IDLE);
  assign done     = st.escape || st.at_limit;

  always_comb begin
    cmd          = '0;
    cmd.capture  = in_valid && in_ready && st.in_image;
    cmd.set_c    = (state == S_CSET);
    cmd.square   = (state == S_SQ);
    cmd.update   = (state == S_UPD) && !done;
    cmd.finish   = (state == S_UPD) && done;
    cmd.div_step = (state == S_DIV);
    cmd.div_bit  = div_bit;
    cmd.out_load = (state == S_OUT) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      div_bit   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd.capture) begin
            state <= S_CSET;
          end
        end
        S_CSET: state <= S_SQ;
        S_SQ:   state <= S_UPD;
        S_UPD: begin
          if (done) begin
            state   <= S_DIV;
            div_bit <= '1;
          end else begin
            state <= S_SQ;
          end
        end
        S_DIV: begin
          if (div_bit == '0) begin
            state <= S_OUT;
          end else begin
            div_bit <= div_bit - 1'b1;
          end
        end
        S_OUT: begin
          if (cmd.out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `MEP_ASSERT_NOW(a_load_into_free_slot, cmd.out_load, !out_valid || out_ready)
  `MEP_ASSERT_NOW(a_no_update_after_end, cmd.update, !st.escape && !st.at_limit)
  `MEP_ASSERT_NEXT(a_load_shows_result, cmd.out_load, out_valid)

endmodule

>>> hw/rtl/mandelbrot_escape_pixel.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_pixel
// Escape-time evaluation of one Mandelbrot pixel per transfer.
// ----------------------------------------------------------------------------
// One pixel is worked at a time. After an input transfer the block forms c,
// then runs each iteration as a square on three 32x32 multipliers and then
// an add and saturate, up to max_iters iterations (255 by default), plus one
// more such pair for the final escape test, then a restoring division for
// the shade with one step per shade bit, then loads the output register once
// it is free and returns to idle before the next input transfer.
// in_ready returns the cycle after the result is loaded; the result may
// wait in the output register while the next pixel runs. Pixels outside
// img_width x img_height are taken and dropped without a result.
// ----------------------------------------------------------------------------
module mandelbrot_escape_pixel import mep_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  mep_in_t                   in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output mep_out_t                  out_data,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_WIDTH-1:0]  cfg_addr,
  input  logic [CFG_DATA_WIDTH-1:0] cfg_wdata
);

  mep_cmd_t    cmd;
  mep_status_t st;

  mep_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  mep_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .st        (st),
    .out_data  (out_data)
  );

endmodule
